// File: hw/rtl/lmmp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lmmp_pkg;

	localparam int NUM_FEATURES = 12;
	localparam int POS_W        = 5;
	localparam int IDX_W        = 4;
	localparam int VALUE_W      = 16;
	localparam int DIFF_W       = 17;
	localparam int COEF_W       = 15;
	localparam int PROD_W       = 32;
	localparam int SUM_W        = 32;
	localparam int BIASED_W     = 34;
	localparam int SCALED_W     = 40;
	localparam int NUM_MODELS   = 3;

	localparam logic [POS_W-1:0] POS_MAX  = 5'd31;
	localparam logic [POS_W-1:0] POS_LAST = 5'(NUM_FEATURES - 1);

	localparam logic [1:0] SEL_HEIGHT = 2'd0;
	localparam logic [1:0] SEL_THETA  = 2'd1;
	localparam logic [1:0] SEL_TILT   = 2'd2;
	localparam logic [1:0] SEL_SPARE  = 2'd3;

	// One classified feature as it travels from the front to the back.
	typedef struct packed {
		logic                     active;
		logic                     last;
		logic                     len_err;
		logic [1:0]               sel;
		logic [IDX_W-1:0]         idx;
		logic signed [DIFF_W-1:0] diff;
	} entry_t;

	// Feature minima in Q10.6.
	function automatic logic signed [DIFF_W-1:0] min_lut(input logic [IDX_W-1:0] i);
		logic signed [DIFF_W-1:0] r;
		case (i)
			4'd0:    r = 17'sd32;
			4'd1:    r = 17'sd64;
			4'd2:    r = 17'sd0;
			4'd3:    r = 17'sd3840;
			4'd4:    r = 17'sd0;
			4'd5:    r = 17'sd3;
			4'd6:    r = -17'sd3840;
			4'd7:    r = 17'sd960;
			4'd8:    r = 17'sd3840;
			4'd9:    r = 17'sd8320;
			4'd10:   r = 17'sd960;
			4'd11:   r = 17'sd3520;
			default: r = 17'sd0;
		endcase
		return r;
	endfunction

	// Weight over feature range, Q16, for each model and feature.
	function automatic logic signed [COEF_W-1:0] coef_lut(input logic [1:0] m,
		input logic [IDX_W-1:0] i);
		logic signed [COEF_W-1:0] r;
		case ({m, i})
			{SEL_HEIGHT, 4'd0}:  r = 15'sd1796;
			{SEL_HEIGHT, 4'd1}:  r = 15'sd1904;
			{SEL_HEIGHT, 4'd2}:  r = -15'sd4232;
			{SEL_HEIGHT, 4'd3}:  r = 15'sd2352;
			{SEL_HEIGHT, 4'd4}:  r = -15'sd95;
			{SEL_HEIGHT, 4'd5}:  r = -15'sd12807;
			{SEL_HEIGHT, 4'd6}:  r = -15'sd25;
			{SEL_HEIGHT, 4'd7}:  r = -15'sd169;
			{SEL_HEIGHT, 4'd8}:  r = -15'sd3095;
			{SEL_HEIGHT, 4'd9}:  r = -15'sd210;
			{SEL_HEIGHT, 4'd10}: r = 15'sd129;
			{SEL_HEIGHT, 4'd11}: r = 15'sd595;
			{SEL_THETA, 4'd0}:   r = 15'sd4678;
			{SEL_THETA, 4'd1}:   r = 15'sd2163;
			{SEL_THETA, 4'd2}:   r = -15'sd3574;
			{SEL_THETA, 4'd3}:   r = 15'sd2531;
			{SEL_THETA, 4'd4}:   r = -15'sd210;
			{SEL_THETA, 4'd5}:   r = -15'sd11295;
			{SEL_THETA, 4'd6}:   r = -15'sd1;
			{SEL_THETA, 4'd7}:   r = -15'sd263;
			{SEL_THETA, 4'd8}:   r = -15'sd3040;
			{SEL_THETA, 4'd9}:   r = -15'sd521;
			{SEL_THETA, 4'd10}:  r = 15'sd181;
			{SEL_THETA, 4'd11}:  r = 15'sd485;
			{SEL_TILT, 4'd0}:    r = 15'sd1298;
			{SEL_TILT, 4'd1}:    r = 15'sd193;
			{SEL_TILT, 4'd2}:    r = -15'sd3451;
			{SEL_TILT, 4'd3}:    r = -15'sd6186;
			{SEL_TILT, 4'd4}:    r = -15'sd1099;
			{SEL_TILT, 4'd5}:    r = -15'sd7864;
			{SEL_TILT, 4'd6}:    r = 15'sd64;
			{SEL_TILT, 4'd7}:    r = 15'sd417;
			{SEL_TILT, 4'd8}:    r = 15'sd7210;
			{SEL_TILT, 4'd9}:    r = -15'sd730;
			{SEL_TILT, 4'd10}:   r = -15'sd117;
			{SEL_TILT, 4'd11}:   r = 15'sd129;
			default:             r = 15'sd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [BIASED_W-1:0] bias_lut(input logic [1:0] m);
		logic signed [BIASED_W-1:0] r;
		case (m)
			SEL_HEIGHT: r = 34'sd15919;
			SEL_THETA:  r = 34'sd21456;
			default:    r = 34'sd44184;
		endcase
		return r;
	endfunction

	function automatic logic [5:0] range_lut(input logic [1:0] m);
		logic [5:0] r;
		case (m)
			SEL_HEIGHT: r = 6'd5;
			SEL_THETA:  r = 6'd42;
			default:    r = 6'd16;
		endcase
		return r;
	endfunction

	function automatic logic signed [9:0] label_min_lut(input logic [1:0] m);
		logic signed [9:0] r;
		case (m)
			SEL_HEIGHT: r = 10'sd0;
			SEL_THETA:  r = 10'sd0;
			default:    r = -10'sd384;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/lmmp_front.sv
`timescale 1ns / 1ps
`default_nettype none

// Tracks the feature position, classifies each accepted item and removes the
// feature minimum.
module lmmp_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          accept,
	input  wire logic [1:0]                    func,
	input  wire logic signed [lmmp_pkg::VALUE_W-1:0] feature_value,
	input  wire logic                          last,
	output lmmp_pkg::entry_t                   entry
);

	logic [lmmp_pkg::POS_W-1:0] pos_q;
	logic [lmmp_pkg::IDX_W-1:0] idx;
	logic                       active;

	assign active = (pos_q < lmmp_pkg::POS_W'(lmmp_pkg::NUM_FEATURES));
	assign idx    = pos_q[lmmp_pkg::IDX_W-1:0];

	always_comb begin
		entry.active  = active;
		entry.last    = last;
		entry.len_err = (pos_q != lmmp_pkg::POS_LAST);
		entry.sel     = (func == lmmp_pkg::SEL_SPARE) ? lmmp_pkg::SEL_TILT : func;
		entry.idx     = idx;
		if (active) begin
			entry.diff = lmmp_pkg::DIFF_W'(feature_value) - lmmp_pkg::min_lut(idx);
		end else begin
			entry.diff = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			if (last) begin
				pos_q <= '0;
			end else if (pos_q != lmmp_pkg::POS_MAX) begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/lmmp_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// Four-entry queue between the front and the back.
module lmmp_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire lmmp_pkg::entry_t wr_entry,
	output logic                  full,
	input  wire logic             pop,
	output logic                  nonempty,
	output lmmp_pkg::entry_t      rd_entry
);

	lmmp_pkg::entry_t slots_q [4];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [2:0] count_q;

	assign full     = (count_q == 3'd4);
	assign nonempty = (count_q != 3'd0);
	assign rd_entry = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/lmmp_back.sv
`timescale 1ns / 1ps
`default_nettype none

// Weights each feature into the three model sums and, on the last item of a
// vector, denormalizes the chosen sum into the output register.
module lmmp_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          head_valid,
	input  wire lmmp_pkg::entry_t              head,
	output logic                               pop,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [15:0]                        m_tdata,
	output logic                               m_tuser
);

	localparam int M = lmmp_pkg::NUM_MODELS;

	logic en;

	logic signed [lmmp_pkg::PROD_W-1:0] prod [M];
	logic signed [lmmp_pkg::PROD_W-1:0] prod_s1 [M];
	logic                               valid_s1;
	logic                               last_s1;
	logic                               err_s1;
	logic [1:0]                         sel_s1;

	logic signed [lmmp_pkg::SUM_W-1:0]  sum_q [M];
	logic signed [lmmp_pkg::SUM_W-1:0]  new_sum [M];
	logic signed [lmmp_pkg::PROD_W:0]   rounded [M];

	logic                               valid_s2;
	logic                               err_s2;
	logic [1:0]                         sel_s2;
	logic signed [lmmp_pkg::SUM_W-1:0]  sum_s2;

	logic                               valid_s3;
	logic                               err_s3;
	logic [1:0]                         sel_s3;
	logic signed [lmmp_pkg::BIASED_W-1:0] biased_s3;

	logic                               valid_s4;
	logic                               err_s4;
	logic [1:0]                         sel_s4;
	logic signed [lmmp_pkg::SCALED_W-1:0] scaled_s4;

	logic signed [lmmp_pkg::SCALED_W-1:0] half_up;
	logic signed [30:0]                 label_val;
	logic signed [15:0]                 sat_val;

	logic                               out_valid_q;
	logic [15:0]                        out_pred_q;
	logic                               out_err_q;

	// The whole back end moves together; it halts only while a result waits.
	assign en  = !out_valid_q || m_tready;
	assign pop = head_valid && en;

	always_comb begin
		for (int m = 0; m < M; m++) begin
			prod[m] = lmmp_pkg::PROD_W'(head.diff)
				* lmmp_pkg::PROD_W'(lmmp_pkg::coef_lut(2'(m), head.idx));
			rounded[m] = (lmmp_pkg::PROD_W + 1)'(prod_s1[m]) + 33'sd32;
			new_sum[m] = sum_q[m] + lmmp_pkg::SUM_W'(rounded[m] >>> 6);
		end
	end

	// Round half up at the 1/64 step, then add the label minimum and clip.
	always_comb begin
		half_up   = scaled_s4 + 40'sd512;
		label_val = 31'(half_up >>> 10) + 31'(lmmp_pkg::label_min_lut(sel_s4));
		if (label_val > 31'sd32767) begin
			sat_val = 16'sh7fff;
		end else if (label_val < -31'sd32768) begin
			sat_val = 16'sh8000;
		end else begin
			sat_val = 16'(label_val);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int m = 0; m < M; m++) begin
				prod_s1[m] <= head.active ? prod[m] : '0;
			end
			last_s1   <= head.last;
			err_s1    <= head.len_err;
			sel_s1    <= head.sel;
			sum_s2    <= new_sum[sel_s1];
			err_s2    <= err_s1;
			sel_s2    <= sel_s1;
			biased_s3 <= lmmp_pkg::BIASED_W'(sum_s2) + lmmp_pkg::bias_lut(sel_s2);
			err_s3    <= err_s2;
			sel_s3    <= sel_s2;
			scaled_s4 <= lmmp_pkg::SCALED_W'(biased_s3)
				* lmmp_pkg::SCALED_W'($signed({1'b0, lmmp_pkg::range_lut(sel_s3)}));
			err_s4    <= err_s3;
			sel_s4    <= sel_s3;
			if (valid_s4) begin
				out_pred_q <= sat_val;
				out_err_q  <= err_s4;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
			for (int m = 0; m < M; m++) begin
				sum_q[m] <= '0;
			end
		end else if (en) begin
			valid_s1    <= pop;
			valid_s2    <= valid_s1 && last_s1;
			valid_s3    <= valid_s2;
			valid_s4    <= valid_s3;
			out_valid_q <= valid_s4;
			if (valid_s1) begin
				for (int m = 0; m < M; m++) begin
					sum_q[m] <= last_s1 ? '0 : new_sum[m];
				end
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_pred_q;
	assign m_tuser  = out_err_q;

endmodule

`default_nettype wire

// File: hw/rtl/linear_model_min_max_predictor_top.sv
// A last item passes the queue, the product, sum, bias and scale registers and output register.
// Throughput: one item per cycle while no result waits; front and back each take one a cycle.
// A result that is not taken stalls the back, and the four-entry queue then fills.
// Reset: arst_n clears the position counter, the queue, the three model sums and all valid flags.
`timescale 1ns / 1ps
`default_nettype none

// Linear-model predictor with min-max scaling. The front part counts the
// feature position of each incoming item, picks the model for a last item and
// subtracts the feature minimum. A short queue decouples it from the back part,
// which multiplies each centered feature by the three per-model coefficients,
// accumulates the three sums, and on the last item of a vector turns the chosen
// sum into a saturated Q10.6 label through a short pipeline. The back part holds
// the result in an output register; as long as that register can be emptied
// the back end moves every cycle.
module linear_model_min_max_predictor_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input channel.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,  // [15:0] feature_value
	input  wire logic [1:0]  s_tuser,  // [1:0] func
	input  wire logic        s_tlast,
	// Result channel.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,  // [15:0] prediction
	output logic             m_tuser   // [0] length_error
);

	logic             accept;
	logic             q_full;
	logic             q_nonempty;
	logic             q_pop;
	lmmp_pkg::entry_t front_entry;
	lmmp_pkg::entry_t head_entry;

	// An item is taken whenever the queue has room.
	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	lmmp_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.func          (s_tuser),
		.feature_value ($signed(s_tdata)),
		.last          (s_tlast),
		.entry         (front_entry)
	);

	lmmp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.wr_entry (front_entry),
		.full     (q_full),
		.pop      (q_pop),
		.nonempty (q_nonempty),
		.rd_entry (head_entry)
	);

	lmmp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_nonempty),
		.head       (head_entry),
		.pop        (q_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

// Testbench for the min-max scaled linear-model label predictor.
// Feature vectors go in on the slave-side stream as signed Q10.6 items. An in-bench
// predictor keeps its own three model sums and feature position. It works out the
// label that each item marked last should produce, and the monitor compares every
// result the block sends with the oldest label still waiting.
module tb;

	localparam int CLK_HALF    = 5;
	localparam int RESET_LEN   = 6;
	localparam int ITEM_TARGET = 1050;
	localparam int CYCLE_LIMIT = 250000;
	localparam int TAIL_CYCLES = 24;
	localparam int MAX_REPORTS = 10;

	typedef struct {
		logic [1:0]         func;
		logic signed [15:0] value;
		logic               last;
	} feature_item_t;

	typedef struct {
		logic [15:0] prediction;
		logic        length_error;
	} label_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic signed [15:0] s_tdata = '0;
	logic [1:0]         s_tuser = '0;
	logic               s_tlast = 1'b0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [15:0]        m_tdata;
	logic               m_tuser;

	linear_model_min_max_predictor_top DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// Feature minima in Q10.6, and the Q16 weight-over-range coefficients laid out
	// as model * 12 + feature, in the order height, theta, tilt.
	int feature_floor [0:11] = '{32, 64, 0, 3840, 0, 3, -3840, 960, 3840, 8320, 960, 3520};
	int scaled_weight [0:35] = '{
		1796, 1904, -4232, 2352, -95, -12807, -25, -169, -3095, -210, 129, 595,
		4678, 2163, -3574, 2531, -210, -11295, -1, -263, -3040, -521, 181, 485,
		1298, 193, -3451, -6186, -1099, -7864, 64, 417, 7210, -730, -117, 129
	};

	feature_item_t      pending_features [$];
	label_t             label_queue [$];
	logic signed [31:0] model_sum [0:2] = '{32'sd0, 32'sd0, 32'sd0};
	logic [4:0]         feature_pos = '0;
	int                 mismatches = 0;
	int                 items_queued = 0;
	int                 cycle_count = 0;

	// Folds one accepted feature into the three model sums. On the item marked
	// last it also turns the chosen sum into the expected label and clears the
	// sums for the next vector.
	task automatic absorb_feature(input logic [1:0] func, input logic signed [15:0] value,
		input logic last);
		longint diff;
		longint term;
		longint biased;
		longint scaled;
		longint bias;
		longint span;
		longint label_floor;
		int     model;
		int     sel;
		label_t label;
		if (feature_pos < 5'(lmmp_pkg::NUM_FEATURES)) begin
			diff = longint'(value) - longint'(feature_floor[feature_pos]);
			for (model = 0; model < 3; model++) begin
				term = (diff * longint'(scaled_weight[model * 12 + feature_pos]) + 32) >>> 6;
				model_sum[model] = model_sum[model] + 32'(term);
			end
		end
		if (!last) begin
			if (feature_pos != lmmp_pkg::POS_MAX)
				feature_pos = feature_pos + 5'd1;
		end else begin
			// The spare selector code falls back to the tilt model.
			case (func)
				lmmp_pkg::SEL_HEIGHT: begin
					sel = 0; bias = 15919; span = 5; label_floor = 0;
				end
				lmmp_pkg::SEL_THETA: begin
					sel = 1; bias = 21456; span = 42; label_floor = 0;
				end
				default: begin
					sel = 2; bias = 44184; span = 16; label_floor = -384;
				end
			endcase
			biased = longint'(model_sum[sel]) + bias;
			scaled = ((biased * span + 512) >>> 10) + label_floor;
			if (scaled > 32767)
				scaled = 32767;
			if (scaled < -32768)
				scaled = -32768;
			label.prediction = 16'(scaled);
			label.length_error = (int'(feature_pos) + 1 != lmmp_pkg::NUM_FEATURES);
			label_queue.push_back(label);
			for (model = 0; model < 3; model++)
				model_sum[model] = '0;
			feature_pos = '0;
		end
	endtask

	// Sender: takes items from the pending queue in bursts of random length with
	// random gaps between them. The predictor sees each item as it is accepted.
	int burst_left = 1;
	int gap_left = 0;

	always @(posedge clk) begin : feature_driver
		feature_item_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				absorb_feature(s_tuser, s_tdata, s_tlast);
			if (!s_tvalid || s_tready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					s_tvalid <= 1'b0;
				end else if (pending_features.size() != 0) begin
					nxt = pending_features.pop_front();
					s_tdata <= nxt.value;
					s_tuser <= nxt.func;
					s_tlast <= nxt.last;
					s_tvalid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 40);
						// Many bursts run straight into the next one.
						if ($urandom_range(0, 2) == 0)
							gap_left <= 0;
						else if ($urandom_range(0, 9) == 0)
							gap_left <= $urandom_range(10, 20);
						else
							gap_left <= $urandom_range(1, 5);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: switches between always ready, coin-flip, mostly stalled and a
	// full stall, each held for a random stretch of cycles.
	int stall_mode = 0;
	int mode_left = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				stall_mode <= $urandom_range(0, 3);
				mode_left <= $urandom_range(8, 64);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (stall_mode)
				0:       m_tready <= 1'b1;
				1:       m_tready <= $urandom_range(0, 1);
				2:       m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= 1'b0;
			endcase
		end
	end

	task automatic note_mismatch(input string what, input label_t want);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("mismatch (%s) at %0t: expected prediction %0d length_error %0b, got %0d %0b",
				what, $realtime, $signed(want.prediction), want.length_error,
				$signed(m_tdata), m_tuser);
	endtask

	// Result monitor: every accepted result is matched against the oldest label.
	always @(posedge clk) begin : label_monitor
		label_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (label_queue.size() == 0) begin
				want.prediction = 'x;
				want.length_error = 1'bx;
				note_mismatch("no result expected", want);
			end else begin
				want = label_queue.pop_front();
				if (m_tdata !== want.prediction || m_tuser !== want.length_error)
					note_mismatch("wrong label", want);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic queue_feature(input logic [1:0] func, input logic signed [15:0] value,
		input logic last);
		feature_item_t item;
		item.func = func;
		item.value = value;
		item.last = last;
		pending_features.push_back(item);
		items_queued++;
	endtask

	// Mostly plausible raw readings, with full-range noise and the extremes mixed in.
	function automatic logic signed [15:0] pick_value();
		case ($urandom_range(0, 9))
			0:       return 16'sh7FFF;
			1:       return 16'sh8000;
			2, 3, 4: return 16'($urandom);
			default: return 16'($urandom_range(0, 12000)) - 16'sd3840;
		endcase
	endfunction

	// Queues one vector whose last item picks the model; non-last items carry a
	// random selector, which the block must ignore.
	task automatic queue_vector(input int len);
		int k;
		for (k = 0; k < len; k++)
			queue_feature(2'($urandom_range(0, 3)), pick_value(), k == len - 1);
	endtask

	// Mostly well-formed twelve-item vectors; the rest are short or overlong,
	// some long enough to pin the position counter at its top.
	task automatic queue_random_vectors(input int item_goal);
		int len;
		while (items_queued < item_goal) begin
			case ($urandom_range(0, 19))
				0, 1:    len = $urandom_range(1, 11);
				2:       len = $urandom_range(13, 20);
				3:       len = $urandom_range(30, 40);
				default: len = lmmp_pkg::NUM_FEATURES;
			endcase
			queue_vector(len);
		end
	endtask

	// Holds the stimulus back until everything queued has gone through the block.
	task automatic wait_until_drained();
		while (pending_features.size() != 0 || s_tvalid || label_queue.size() != 0)
			@(posedge clk);
	endtask

	initial begin : stimulus
		int k;
		repeat (RESET_LEN) @(posedge clk);
		arst_n <= 1'b1;

		// A full vector at the positive extreme, read by the theta model.
		for (k = 0; k < lmmp_pkg::NUM_FEATURES; k++)
			queue_feature(lmmp_pkg::SEL_HEIGHT, 16'sh7FFF,
				k == lmmp_pkg::NUM_FEATURES - 1 ? 1'b1 : 1'b0);
		pending_features[$].func = lmmp_pkg::SEL_THETA;
		// One item too many at the negative extreme, with the spare selector code.
		for (k = 0; k <= lmmp_pkg::NUM_FEATURES; k++)
			queue_feature(lmmp_pkg::SEL_TILT, 16'sh8000,
				k == lmmp_pkg::NUM_FEATURES ? 1'b1 : 1'b0);
		pending_features[$].func = lmmp_pkg::SEL_SPARE;
		// Vectors of a single item, for the height and tilt models.
		queue_feature(lmmp_pkg::SEL_HEIGHT, 16'sd0, 1'b1);
		queue_feature(lmmp_pkg::SEL_TILT, -16'sd1, 1'b1);
		wait_until_drained();

		queue_random_vectors(ITEM_TARGET / 2);
		wait_until_drained();
		queue_random_vectors(ITEM_TARGET);
		wait_until_drained();

		// Give the block time to show any result that nothing asked for.
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/lmmp_pkg.sv
hw/rtl/lmmp_front.sv
hw/rtl/lmmp_queue.sv
hw/rtl/lmmp_back.sv
hw/rtl/linear_model_min_max_predictor_top.sv
tb/sv/tb.sv
